[hdl/assert_macros.svh]
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while the synchronous reset is low.
`define QTAU_ASSERT(label, clk, rstn, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Clocked condition that must never hold outside reset.
`define QTAU_NEVER(label, clk, rstn, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) else $error(msg);

`endif

[hdl/qtau_pkg.sv]
package qtau_pkg;

  // Deepest quadtree level; deeper requests saturate to it.
  localparam int unsigned MAX_LEVEL = 31;

  // Operation codes carried in the mode field.
  typedef enum logic [2:0] {
    MODE_ENCODE = 3'd0,
    MODE_DECODE = 3'd1,
    MODE_TOP    = 3'd2,
    MODE_BOTTOM = 3'd3,
    MODE_LEFT   = 3'd4,
    MODE_RIGHT  = 3'd5
  } qtau_mode_t;

  // Request payload.
  typedef struct packed {
    logic [2:0]  mode;
    logic [30:0] coord_x;
    logic [30:0] coord_y;
    logic [61:0] tile_code;
    logic [4:0]  level;
  } qtau_in_t;

  // Result payload.
  typedef struct packed {
    logic [63:0] id_out;
    logic [30:0] x_out;
    logic [30:0] y_out;
    logic        beyond_level;
  } qtau_out_t;

  // Stage 1 register: masked coordinates of the addressed tile.
  typedef struct packed {
    logic        valid;
    logic [2:0]  mode;
    logic [4:0]  lvl;
    logic [30:0] lmask;
    logic [30:0] x;
    logic [30:0] y;
    logic [61:0] code;
  } qtau_s1_t;

  // Stage 2 register: coordinates after the neighbor step, one bit wider.
  typedef struct packed {
    logic        valid;
    logic [2:0]  mode;
    logic [4:0]  lvl;
    logic [31:0] x;
    logic [31:0] y;
    logic        beyond;
    logic [61:0] code;
  } qtau_s2_t;

  // Bit i of a goes to bit 2i, bit i of b to bit 2i+1.
  function automatic logic [63:0] zpack(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] c;
    c = '0;
    for (int i = 0; i < 32; i++) begin
      c[2*i]   = a[i];
      c[2*i+1] = b[i];
    end
    return c;
  endfunction

  // Even bits of a code.
  function automatic logic [30:0] zsplit_x(input logic [61:0] code);
    logic [30:0] a;
    a = '0;
    for (int i = 0; i < 31; i++) begin
      a[i] = code[2*i];
    end
    return a;
  endfunction

  // Odd bits of a code.
  function automatic logic [30:0] zsplit_y(input logic [61:0] code);
    logic [30:0] b;
    b = '0;
    for (int i = 0; i < 31; i++) begin
      b[i] = code[2*i+1];
    end
    return b;
  endfunction

  // First absolute id of a level, (4^n-1)/3: a one in every even bit below 2n.
  function automatic logic [63:0] level_base(input logic [4:0] lvl);
    logic [63:0] b;
    b = '0;
    for (int i = 0; i < 31; i++) begin
      if (i < int'(lvl)) begin
        b[2*i] = 1'b1;
      end
    end
    return b;
  endfunction

  // Low lvl bits set; a level of 31 gives all ones.
  function automatic logic [30:0] level_mask(input logic [4:0] lvl);
    return ~({31{1'b1}} << lvl);
  endfunction

endpackage

[hdl/qtau_unpack.sv]
module qtau_unpack #(
  parameter int unsigned MAX_LEVEL = qtau_pkg::MAX_LEVEL
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  qtau_pkg::qtau_in_t in_req,
  output qtau_pkg::qtau_s1_t s1_out
);

  logic [4:0]         lvl_sat;
  logic [30:0]        lmask;
  qtau_pkg::qtau_s1_t s1_nxt;
  qtau_pkg::qtau_s1_t s1_r;

  // Saturate the level and pick the coordinates: given for encode, split otherwise.
  always_comb begin
    if (int'(in_req.level) > int'(MAX_LEVEL)) begin
      lvl_sat = 5'(MAX_LEVEL);
    end else begin
      lvl_sat = in_req.level;
    end
    lmask = qtau_pkg::level_mask(lvl_sat);
    s1_nxt.valid = in_valid;
    s1_nxt.mode  = in_req.mode;
    s1_nxt.lvl   = lvl_sat;
    s1_nxt.lmask = lmask;
    s1_nxt.code  = in_req.tile_code;
    if (in_req.mode == qtau_pkg::MODE_ENCODE) begin
      s1_nxt.x = in_req.coord_x & lmask;
      s1_nxt.y = in_req.coord_y & lmask;
    end else begin
      s1_nxt.x = qtau_pkg::zsplit_x(in_req.tile_code) & lmask;
      s1_nxt.y = qtau_pkg::zsplit_y(in_req.tile_code) & lmask;
    end
  end

  // Stage register; only the valid bit is reset.
  always_ff @(posedge clk) begin
    s1_r <= s1_nxt;
    if (!rst_n) begin
      s1_r.valid <= 1'b0;
    end
  end

  assign s1_out = s1_r;

endmodule

[hdl/qtau_step.sv]
module qtau_step (
  input  logic               clk,
  input  logic               rst_n,
  input  qtau_pkg::qtau_s1_t s1_in,
  output qtau_pkg::qtau_s2_t s2_out
);

  logic [31:0]        x_ext;
  logic [31:0]        y_ext;
  qtau_pkg::qtau_s2_t s2_nxt;
  qtau_pkg::qtau_s2_t s2_r;

  // Neighbor step: top and left clamp at zero, bottom and right may leave the grid.
  always_comb begin
    x_ext = {1'b0, s1_in.x};
    y_ext = {1'b0, s1_in.y};
    s2_nxt.valid  = s1_in.valid;
    s2_nxt.mode   = s1_in.mode;
    s2_nxt.lvl    = s1_in.lvl;
    s2_nxt.code   = s1_in.code;
    s2_nxt.x      = x_ext;
    s2_nxt.y      = y_ext;
    s2_nxt.beyond = 1'b0;
    unique case (s1_in.mode)
      qtau_pkg::MODE_TOP: begin
        if (s1_in.y != '0) begin
          s2_nxt.y = y_ext - 32'd1;
        end
      end
      qtau_pkg::MODE_BOTTOM: begin
        s2_nxt.y      = y_ext + 32'd1;
        s2_nxt.beyond = (s1_in.y == s1_in.lmask);
      end
      qtau_pkg::MODE_LEFT: begin
        if (s1_in.x != '0) begin
          s2_nxt.x = x_ext - 32'd1;
        end
      end
      qtau_pkg::MODE_RIGHT: begin
        s2_nxt.x      = x_ext + 32'd1;
        s2_nxt.beyond = (s1_in.x == s1_in.lmask);
      end
      default: begin
        s2_nxt.beyond = 1'b0;
      end
    endcase
  end

  // Stage register; only the valid bit is reset.
  always_ff @(posedge clk) begin
    s2_r <= s2_nxt;
    if (!rst_n) begin
      s2_r.valid <= 1'b0;
    end
  end

  assign s2_out = s2_r;

endmodule

[hdl/qtau_pack.sv]
module qtau_pack (
  input  logic                clk,
  input  logic                rst_n,
  input  qtau_pkg::qtau_s2_t  s2_in,
  output logic                out_strobe,
  output qtau_pkg::qtau_out_t out_res
);

  logic [63:0]         zcode;
  qtau_pkg::qtau_out_t res_nxt;
  qtau_pkg::qtau_out_t res_r;
  logic                strobe_r;

  // Interleave the coordinates and form the id for the mode.
  always_comb begin
    zcode   = qtau_pkg::zpack(s2_in.x, s2_in.y);
    res_nxt = '0;
    unique case (s2_in.mode)
      qtau_pkg::MODE_ENCODE: begin
        res_nxt.id_out = zcode + qtau_pkg::level_base(s2_in.lvl);
        res_nxt.x_out  = s2_in.x[30:0];
        res_nxt.y_out  = s2_in.y[30:0];
      end
      qtau_pkg::MODE_DECODE: begin
        res_nxt.id_out = {2'b00, s2_in.code};
        res_nxt.x_out  = s2_in.x[30:0];
        res_nxt.y_out  = s2_in.y[30:0];
      end
      qtau_pkg::MODE_TOP, qtau_pkg::MODE_BOTTOM,
      qtau_pkg::MODE_LEFT, qtau_pkg::MODE_RIGHT: begin
        res_nxt.id_out       = zcode;
        res_nxt.x_out        = s2_in.x[30:0];
        res_nxt.y_out        = s2_in.y[30:0];
        res_nxt.beyond_level = s2_in.beyond;
      end
      default: begin
        res_nxt = '0;
      end
    endcase
  end

  // Output register; the strobe is cleared by reset.
  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= s2_in.valid;
    end
  end

  assign out_strobe = strobe_r;
  assign out_res    = res_r;

endmodule

[hdl/quadtree_tile_address_unit_core.sv]
// A request accepted at a clock edge passes through the split, step and interleave registers;
// its result is then on the outputs for one cycle, marked by out_strobe.
// Throughput: one request per cycle while busy is low; three register stages (split,
// step, interleave and level-base add) each take a new request at every edge.
// Reset: synchronous, active low; clears the stage valid bits and holds busy high
// until the first edge after reset is released. Results cannot be stalled.
module quadtree_tile_address_unit_core #(
  parameter int unsigned MAX_LEVEL = qtau_pkg::MAX_LEVEL
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  qtau_pkg::qtau_in_t  in_req,
  output logic                out_strobe,
  output qtau_pkg::qtau_out_t out_res
);

  logic               busy_r;
  logic               accept;
  qtau_pkg::qtau_s1_t s1;
  qtau_pkg::qtau_s2_t s2;

  // Busy only while in reset and for the edge that leaves it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  assign busy   = busy_r;
  assign accept = start & ~busy_r;

  // Stage 1: level saturation and coordinate split.
  qtau_unpack #(
    .MAX_LEVEL (MAX_LEVEL)
  ) u_unpack (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (accept),
    .in_req   (in_req),
    .s1_out   (s1)
  );

  // Stage 2: neighbor step and edge flag.
  qtau_step u_step (
    .clk    (clk),
    .rst_n  (rst_n),
    .s1_in  (s1),
    .s2_out (s2)
  );

  // Stage 3: Z-order interleave, level base and result register.
  qtau_pack u_pack (
    .clk        (clk),
    .rst_n      (rst_n),
    .s2_in      (s2),
    .out_strobe (out_strobe),
    .out_res    (out_res)
  );

endmodule

[hdl/qtau_chk.sv]
`include "assert_macros.svh"

module qtau_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input qtau_pkg::qtau_in_t  in_req,
  input logic                out_strobe,
  input qtau_pkg::qtau_out_t out_res
);

  // Every accepted request is followed by a result marked by out_strobe.
  `QTAU_ASSERT(a_latency, clk, rst_n, (start && !busy) |-> ##3 out_strobe, "result missing after request")

  // No result appears without an accepted request before it.
  `QTAU_ASSERT(a_no_spurious, clk, rst_n, out_strobe |-> $past(start && !busy, 3), "result without request")

  // The edge flag only comes from a bottom or right step.
  `QTAU_ASSERT(a_beyond_mode, clk, rst_n, (out_strobe && out_res.beyond_level) |-> ($past(in_req.mode, 3) == qtau_pkg::MODE_BOTTOM || $past(in_req.mode, 3) == qtau_pkg::MODE_RIGHT), "edge flag on wrong mode")

  // Decode echoes the request code unchanged.
  `QTAU_ASSERT(a_decode_echo, clk, rst_n, (out_strobe && $past(in_req.mode, 3) == qtau_pkg::MODE_DECODE) |-> (out_res.id_out == {2'b00, $past(in_req.tile_code, 3)}), "decode id mismatch")

  // Once out of reset the unit never refuses a request.
  `QTAU_NEVER(a_busy_idle, clk, rst_n, $past(rst_n) && busy, "busy after reset")

endmodule

bind quadtree_tile_address_unit_core qtau_chk u_qtau_chk (.*);
